[hw/rtl/hka_pkg.sv]
package hka_pkg;

   // report and result limits
   localparam int unsigned REPORT_KEYS = 6;
   localparam int unsigned MAX_RESULTS = 7;
   localparam int unsigned IDX_W       = 5;
   localparam int unsigned TIME_W      = 48;
   localparam int unsigned REG_W       = 24;
   localparam int unsigned CNT_W       = 3;

   // command codes
   localparam logic [1:0] CMD_REPORT = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_TABLE  = 2'd2;

   // result kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_LED  = 1'b1;

   // register indexes
   localparam logic REG_DELAY  = 1'b0;
   localparam logic REG_PERIOD = 1'b1;

   // key and character constants
   localparam logic [7:0] CAPS_KEY   = 8'h39;
   localparam logic [7:0] MOD_CTRL   = 8'h11;
   localparam logic [7:0] MOD_SHIFT  = 8'h22;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [1:0] CTRL_RANGE = 2'b01;
   localparam logic [7:0] CTRL_MASK  = 8'h1F;

   // controller to datapath
   typedef struct packed {
      logic             start;
      logic             write_ram;
      logic             free_slots;
      logic             emit_led;
      logic             look_shift;
      logic             take_char;
      logic             emit_char;
      logic             tick_emit;
      logic             finish_report;
      logic             flush;
      logic [IDX_W-1:0] idx;
   } hka_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit_ok;
      logic out_free;
      logic pend_valid;
      logic caps_edge;
      logic key_skip;
      logic due;
   } hka_status_type;

endpackage

[hw/rtl/hka_req_if.sv]
interface hka_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  modifier;
   logic [7:0]  key0;
   logic [7:0]  key1;
   logic [7:0]  key2;
   logic [7:0]  key3;
   logic [7:0]  key4;
   logic [7:0]  key5;
   logic [47:0] now_us;
   logic [7:0]  table_index;
   logic [7:0]  table_value;

   modport source (
      output valid, command, modifier, key0, key1, key2, key3, key4, key5,
             now_us, table_index, table_value,
      input  ready
   );
   modport sink (
      input  valid, command, modifier, key0, key1, key2, key3, key4, key5,
             now_us, table_index, table_value,
      output ready
   );
endinterface

[hw/rtl/hka_rsp_if.sv]
interface hka_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] character;
   logic       caps_led;
   logic       last;

   modport source (output valid, kind, character, caps_led, last, input ready);
   modport sink (input valid, kind, character, caps_led, last, output ready);
endinterface

[hw/rtl/hka_ram.sv]
module hka_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/hka_ctrl.sv]
module hka_ctrl
   import hka_pkg::*;
#(
   parameter int KEY_SLOTS = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_command,
   output logic           req_ready,
   input  hka_status_type stat,
   output hka_cmd_type    cmd
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_WRITE = 10'b0000000010,
      S_FREE  = 10'b0000000100,
      S_CAPS  = 10'b0000001000,
      S_KEY   = 10'b0000010000,
      S_LOOK1 = 10'b0000100000,
      S_LOOK2 = 10'b0001000000,
      S_EMIT  = 10'b0010000000,
      S_TICK  = 10'b0100000000,
      S_FLUSH = 10'b1000000000
   } hka_state_type;

   hka_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.idx   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               case (req_command)
                  CMD_REPORT: state_in = S_FREE;
                  CMD_TICK:   state_in = S_TICK;
                  CMD_TABLE:  state_in = S_WRITE;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_WRITE: begin
            cmd.write_ram = 1'b1;
            state_in      = S_IDLE;
         end
         S_FREE: begin
            cmd.free_slots = 1'b1;
            state_in       = S_CAPS;
         end
         S_CAPS: begin
            if (!stat.caps_edge) begin
               state_in = S_KEY;
            end else if (stat.emit_ok) begin
               cmd.emit_led = 1'b1;
               state_in     = S_KEY;
            end
         end
         S_KEY: begin
            if (idx_ff == IDX_W'(REPORT_KEYS)) begin
               cmd.finish_report = 1'b1;
               state_in          = S_FLUSH;
            end else if (stat.key_skip) begin
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               state_in = S_LOOK1;
            end
         end
         S_LOOK1: begin
            cmd.look_shift = 1'b1;
            state_in       = S_LOOK2;
         end
         S_LOOK2: begin
            cmd.take_char = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (stat.emit_ok) begin
               cmd.emit_char = 1'b1;
               idx_in        = idx_ff + IDX_W'(1);
               state_in      = S_KEY;
            end
         end
         S_TICK: begin
            if (idx_ff == IDX_W'(KEY_SLOTS)) begin
               state_in = S_FLUSH;
            end else if (!stat.due) begin
               idx_in = idx_ff + IDX_W'(1);
            end else if (stat.emit_ok) begin
               cmd.tick_emit = 1'b1;
               idx_in        = idx_ff + IDX_W'(1);
            end
         end
         S_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTHESIS
   // no held result may linger once the block is back to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stat.pend_valid)
      else $error("held result left behind at idle");
`endif
endmodule

[hw/rtl/hka_dp.sv]
module hka_dp
   import hka_pkg::*;
#(
   parameter int KEY_SLOTS   = 6,
   parameter int KEYMAP_KEYS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  hka_cmd_type       cmd,
   output hka_status_type    stat,
   input  logic [REG_W-1:0]  repeat_delay_us,
   input  logic [REG_W-1:0]  repeat_period_us,
   input  logic [7:0]        req_modifier,
   input  logic [7:0]        req_keys [REPORT_KEYS],
   input  logic [TIME_W-1:0] req_now_us,
   input  logic [7:0]        req_table_index,
   input  logic [7:0]        req_table_value,
   output logic              ram_we,
   output logic [7:0]        ram_waddr,
   output logic [7:0]        ram_wdata,
   output logic [7:0]        ram_raddr,
   input  logic [7:0]        ram_rdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_character,
   output logic              rsp_caps_led,
   output logic              rsp_last
);
   localparam int RK = (KEY_SLOTS < REPORT_KEYS) ? KEY_SLOTS : REPORT_KEYS;
   localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   // latched request
   logic [7:0]        mod_ff;
   logic [7:0]        keys_ff [REPORT_KEYS];
   logic [TIME_W-1:0] now_ff;
   logic [7:0]        tindex_ff, tvalue_ff;

   // keyboard state
   logic [7:0]        prev_ff [REPORT_KEYS];
   logic [7:0]        rkey_ff [KEY_SLOTS];
   logic [7:0]        rchar_ff [KEY_SLOTS];
   logic [TIME_W-1:0] rdl_ff [KEY_SLOTS];
   logic              caps_ff, caps_was_ff;
   logic [7:0]        char_ff;
   logic [CNT_W-1:0]  cnt_ff;

   // held result and output register
   logic              pend_valid_ff, pend_kind_ff, pend_caps_ff;
   logic [7:0]        pend_char_ff;
   logic              out_valid_ff, out_kind_ff, out_caps_ff, out_last_ff;
   logic [7:0]        out_char_ff;

   logic [7:0]    cur_key;
   logic          prev_hit, caps_down, shift_sel, lower, in_map;
   logic [7:0]    map_char;
   logic [SW-1:0] sidx, free_idx;
   logic          free_found, slot_ok;
   logic          emit, out_free;
   logic          new_kind, new_caps;
   logic [7:0]    new_char;

   // current report key and its checks
   always_comb begin
      cur_key   = (cmd.idx < IDX_W'(REPORT_KEYS)) ? keys_ff[cmd.idx[2:0]] : '0;
      prev_hit  = 1'b0;
      caps_down = 1'b0;
      for (int i = 0; i < REPORT_KEYS; i++) begin
         if (prev_ff[i] == cur_key) prev_hit = 1'b1;
         if (keys_ff[i] == CAPS_KEY) caps_down = 1'b1;
      end
   end

   // keymap address and character shaping
   assign lower     = (ram_rdata >= CH_LOWER_A) && (ram_rdata <= CH_LOWER_Z);
   assign shift_sel = ((mod_ff & MOD_SHIFT) != '0) ^ (caps_ff && lower);
   assign ram_raddr = {cur_key[6:0], cmd.look_shift & shift_sel};
   assign in_map    = {1'b0, cur_key} < 9'(KEYMAP_KEYS);

   always_comb begin
      map_char = in_map ? ram_rdata : '0;
      if (((mod_ff & MOD_CTRL) != '0) && (map_char[7:6] == CTRL_RANGE)) begin
         map_char = map_char & CTRL_MASK;
      end
   end

   // first free repeat slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (!free_found && rkey_ff[j] == '0) begin
            free_found = 1'b1;
            free_idx   = SW'(j);
         end
      end
   end

   // tick slot check
   assign sidx    = cmd.idx[SW-1:0];
   assign slot_ok = cmd.idx < IDX_W'(KEY_SLOTS);

   // result selection
   assign emit     = cmd.emit_led | cmd.emit_char | cmd.tick_emit;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      new_kind = KIND_CHAR;
      new_char = char_ff;
      new_caps = caps_ff;
      if (cmd.emit_led) begin
         new_kind = KIND_LED;
         new_char = '0;
         new_caps = !caps_ff;
      end else if (cmd.tick_emit) begin
         new_char = rchar_ff[sidx];
      end
   end

   // status
   always_comb begin
      stat            = '0;
      stat.out_free   = out_free;
      stat.pend_valid = pend_valid_ff;
      stat.emit_ok    = !pend_valid_ff || out_free;
      stat.caps_edge  = caps_down && !caps_was_ff;
      stat.key_skip   = (cur_key == '0) || (cur_key == CAPS_KEY) || prev_hit;
      stat.due        = slot_ok && (rchar_ff[sidx] != '0) &&
                        (now_ff > rdl_ff[sidx]) && (cnt_ff < CNT_W'(MAX_RESULTS));
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mod_ff    <= req_modifier;
         now_ff    <= req_now_us;
         tindex_ff <= req_table_index;
         tvalue_ff <= req_table_value;
         for (int i = 0; i < REPORT_KEYS; i++) begin
            keys_ff[i] <= (i < RK) ? req_keys[i] : '0;
         end
      end
      if (cmd.take_char) begin
         char_ff <= map_char;
      end
   end

   // keyboard state and result path
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REPORT_KEYS; i++) prev_ff[i] <= '0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            rkey_ff[j]  <= '0;
            rchar_ff[j] <= '0;
            rdl_ff[j]   <= '0;
         end
         caps_ff       <= 1'b0;
         caps_was_ff   <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.start) cnt_ff <= '0;
         else if (emit) cnt_ff <= cnt_ff + CNT_W'(1);

         // drop slots whose key was released
         if (cmd.free_slots) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
               logic present;
               present = 1'b0;
               for (int i = 0; i < REPORT_KEYS; i++) begin
                  if (keys_ff[i] == rkey_ff[j]) present = 1'b1;
               end
               if (rkey_ff[j] != '0 && !present) begin
                  rkey_ff[j]  <= '0;
                  rchar_ff[j] <= '0;
               end
            end
         end

         if (cmd.emit_led) caps_ff <= !caps_ff;

         // new key takes a repeat slot
         if (cmd.emit_char && free_found) begin
            rkey_ff[free_idx]  <= cur_key;
            rchar_ff[free_idx] <= char_ff;
            rdl_ff[free_idx]   <= now_ff + TIME_W'(repeat_delay_us);
         end

         if (cmd.tick_emit) begin
            rdl_ff[sidx] <= rdl_ff[sidx] + TIME_W'(repeat_period_us);
         end

         if (cmd.finish_report) begin
            for (int i = 0; i < REPORT_KEYS; i++) prev_ff[i] <= keys_ff[i];
            caps_was_ff <= caps_down;
         end

         // output register handshake, unless it is reloaded below
         if (out_valid_ff && rsp_ready && !cmd.flush && !(emit && pend_valid_ff)) begin
            out_valid_ff <= 1'b0;
         end

         // a new result pushes the held one out, not last
         if (emit) begin
            if (pend_valid_ff) begin
               out_valid_ff <= 1'b1;
               out_kind_ff  <= pend_kind_ff;
               out_char_ff  <= pend_char_ff;
               out_caps_ff  <= pend_caps_ff;
               out_last_ff  <= 1'b0;
            end
            pend_valid_ff <= 1'b1;
            pend_kind_ff  <= new_kind;
            pend_char_ff  <= new_char;
            pend_caps_ff  <= new_caps;
         end else if (cmd.flush) begin
            out_valid_ff  <= 1'b1;
            out_kind_ff   <= pend_kind_ff;
            out_char_ff   <= pend_char_ff;
            out_caps_ff   <= pend_caps_ff;
            out_last_ff   <= 1'b1;
            pend_valid_ff <= 1'b0;
         end
      end
   end

   assign ram_we        = cmd.write_ram;
   assign ram_waddr     = tindex_ff;
   assign ram_wdata     = tvalue_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_character = out_char_ff;
   assign rsp_caps_led  = out_caps_ff;
   assign rsp_last      = out_last_ff;

`ifndef SYNTHESIS
   // a result is produced only when the held one can move on
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (!pend_valid_ff || out_free))
      else $error("result produced while output path is full");

   // caps lock only changes together with an led item
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (caps_ff != $past(caps_ff))) |-> $past(cmd.emit_led))
      else $error("caps lock changed without led item");
`endif
endmodule

[hw/rtl/hid_keyboard_to_ascii_autorepeat_core.sv]
// channel   | direction | handshake      | payload
// req_ch    | in        | valid / ready  | command, modifier, key0..key5, now_us, table_*
// rsp_ch    | out       | valid / ready  | kind, character, caps_led, last
// csr_*     | in        | apb, pready=1  | repeat_delay_us (0x0), repeat_period_us (0x4)
//
// a table write is one sequencer step; a tick visits each repeat slot and can wait on output stalls
// a report visits each report key; each newly pressed key takes two keymap reads
// items are taken one at a time; the last result waits in the output register
// while the next item is accepted
// synchronous reset clears keyboard state and loads the register defaults; the keymap is not cleared
// a stalled result channel holds the sequencer at its next result
module hid_keyboard_to_ascii_autorepeat_core
   import hka_pkg::*;
#(
   parameter int KEY_SLOTS   = 6,
   parameter int KEYMAP_KEYS = 128
) (
   input  logic        clock,
   input  logic        reset,
   hka_req_if.sink     req_ch,
   hka_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [REG_W-1:0] delay_ff, period_ff;
   hka_cmd_type      cmd;
   hka_status_type   stat;
   logic [7:0]       req_keys [REPORT_KEYS];
   logic             ram_we;
   logic [7:0]       ram_waddr, ram_wdata, ram_raddr, ram_rdata;

   // register file
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= REG_W'(500000);
         period_ff <= REG_W'(50000);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_DELAY) delay_ff <= csr_pwdata[REG_W-1:0];
         else period_ff <= csr_pwdata[REG_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_PERIOD) ? {8'd0, period_ff} : {8'd0, delay_ff};

   assign req_keys[0] = req_ch.key0;
   assign req_keys[1] = req_ch.key1;
   assign req_keys[2] = req_ch.key2;
   assign req_keys[3] = req_ch.key3;
   assign req_keys[4] = req_ch.key4;
   assign req_keys[5] = req_ch.key5;

   hka_ctrl #(.KEY_SLOTS(KEY_SLOTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   hka_dp #(.KEY_SLOTS(KEY_SLOTS), .KEYMAP_KEYS(KEYMAP_KEYS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .repeat_delay_us  (delay_ff),
      .repeat_period_us (period_ff),
      .req_modifier     (req_ch.modifier),
      .req_keys         (req_keys),
      .req_now_us       (req_ch.now_us),
      .req_table_index  (req_ch.table_index),
      .req_table_value  (req_ch.table_value),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_kind         (rsp_ch.kind),
      .rsp_character    (rsp_ch.character),
      .rsp_caps_led     (rsp_ch.caps_led),
      .rsp_last         (rsp_ch.last)
   );

   // keymap, unshifted and shifted entry per keycode
   hka_ram #(.WIDTH(8), .DEPTH(256)) u_keymap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );
endmodule

[verif/tb_hid_keyboard_to_ascii_autorepeat_core.sv]
`timescale 1ns / 1ps

module tb_hid_keyboard_to_ascii_autorepeat_core;
   import hka_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] character;
      logic       caps_led;
      logic       last;
   } key_out_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hka_req_if req_ch ();
   hka_rsp_if rsp_ch ();

   hid_keyboard_to_ascii_autorepeat_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [23:0] delay_us, period_us;
   logic [7:0]  keymap_mem [256];
   logic [7:0]  prev_keys [6];
   logic [7:0]  slot_key [6];
   logic [7:0]  slot_char [6];
   logic [47:0] slot_deadline [6];
   logic        caps_on, caps_was_down;
   key_out_t    expected_chars [$];
   int          errors = 0;
   longint      cycle_count = 0;
   logic [47:0] clock_us = 48'd1000;
   int          burst_left = 0;

   function automatic bit key_in(input logic [7:0] keys [6], input logic [7:0] code);
      for (int i = 0; i < 6; i++) if (keys[i] == code) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [7:0] keymap_read(input logic [7:0] key, input bit shift);
      if (key >= 8'd128) return 8'h00;
      return keymap_mem[{key[6:0], shift}];
   endfunction

   task automatic push_char(input logic kind, input logic [7:0] ch);
      key_out_t r;
      r.kind = kind;
      r.character = ch;
      r.caps_led = caps_on;
      r.last = 1'b0;
      expected_chars.push_back(r);
   endtask

   // compute expected results of one item
   task automatic predict_keys(input logic [1:0] cmd, input logic [7:0] modif,
                               input logic [7:0] keys [6], input logic [47:0] now,
                               input logic [7:0] tidx, input logic [7:0] tval);
      int n, base;
      bit ctrl, shift, caps_down;
      logic [7:0] ch;
      key_out_t r;
      n = 0;
      base = expected_chars.size();
      ctrl = (modif & MOD_CTRL) != 0;
      if (cmd == CMD_REPORT) begin
         for (int i = 0; i < 6; i++)
            if (slot_key[i] != 0 && !key_in(keys, slot_key[i])) begin
               slot_key[i] = 0;
               slot_char[i] = 0;
            end
         caps_down = key_in(keys, CAPS_KEY);
         if (caps_down && !caps_was_down) begin
            caps_on = !caps_on;
            push_char(KIND_LED, 8'h00);
            n++;
         end
         for (int i = 0; i < 6; i++) begin
            if (keys[i] == 0 || keys[i] == CAPS_KEY || key_in(prev_keys, keys[i])) continue;
            shift = (modif & MOD_SHIFT) != 0;
            ch = keymap_read(keys[i], 1'b0);
            if (caps_on && ch >= CH_LOWER_A && ch <= CH_LOWER_Z) shift = !shift;
            ch = keymap_read(keys[i], shift);
            if (ctrl) begin
               if (ch >= 8'h60 && ch <= 8'h7F) ch -= 8'h60;
               else if (ch >= 8'h40 && ch <= 8'h5F) ch -= 8'h40;
            end
            for (int j = 0; j < 6; j++)
               if (slot_key[j] == 0) begin
                  slot_key[j] = keys[i];
                  slot_char[j] = ch;
                  slot_deadline[j] = now + 48'(delay_us);
                  break;
               end
            if (n < MAX_RESULTS) begin
               push_char(KIND_CHAR, ch);
               n++;
            end
         end
         prev_keys = keys;
         caps_was_down = caps_down;
      end else if (cmd == CMD_TICK) begin
         for (int i = 0; i < 6 && n < MAX_RESULTS; i++)
            if (slot_char[i] != 0 && now > slot_deadline[i]) begin
               push_char(KIND_CHAR, slot_char[i]);
               n++;
               slot_deadline[i] = slot_deadline[i] + 48'(period_us);
            end
      end else if (cmd == CMD_TABLE) begin
         keymap_mem[tidx] = tval;
      end
      if (n > 0) begin
         r = expected_chars[base + n - 1];
         r.last = 1'b1;
         expected_chars[base + n - 1] = r;
      end
   endtask

   // send one item with burst / gap pacing
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] modif,
                            input logic [7:0] keys [6], input logic [47:0] now,
                            input logic [7:0] tidx = 8'h00, input logic [7:0] tval = 8'h00);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.modifier <= modif;
      req_ch.key0 <= keys[0];
      req_ch.key1 <= keys[1];
      req_ch.key2 <= keys[2];
      req_ch.key3 <= keys[3];
      req_ch.key4 <= keys[4];
      req_ch.key5 <= keys[5];
      req_ch.now_us <= now;
      req_ch.table_index <= tidx;
      req_ch.table_value <= tval;
      do @(posedge clock); while (!req_ch.ready);
      predict_keys(cmd, modif, keys, now, tidx, tval);
   endtask

   task automatic report(input logic [7:0] modif, input logic [7:0] keys [6]);
      clock_us += $urandom_range(1, 20000);
      send_item(CMD_REPORT, modif, keys, clock_us);
   endtask

   task automatic tick(input logic [47:0] now);
      logic [7:0] none [6] = '{default: 8'h00};
      send_item(CMD_TICK, 8'h00, none, now);
   endtask

   task automatic table_write(input logic [7:0] idx, input logic [7:0] val);
      logic [7:0] none [6] = '{default: 8'h00};
      send_item(CMD_TABLE, 8'h00, none, 48'({$urandom, $urandom}), idx, val);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [23:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= {8'h00, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_idx == REG_DELAY) delay_us = value;
      else period_us = value;
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_key();
      case ($urandom_range(0, 9))
         0: return CAPS_KEY;
         1: return 8'($urandom_range(128, 255));
         2, 3: return 8'h00;
         default: return 8'($urandom_range(1, 127));
      endcase
   endfunction

   // keymap load: every entry so no unwritten read can happen
   task automatic test_keymap_load();
      for (int k = 0; k < 256; k++) begin
         logic [7:0] v;
         case ($urandom_range(0, 3))
            0: v = 8'($urandom_range(8'h61, 8'h7A));
            1: v = 8'($urandom_range(8'h40, 8'h5F));
            2: v = 8'($urandom_range(8'h60, 8'h7F));
            default: v = 8'($urandom);
         endcase
         if ($urandom_range(0, 15) == 0) v = 8'h00;
         table_write(8'(k), v);
      end
      // fixed letter for keycode 4 and 0xFF entry
      table_write(8'd8, 8'h61);
      table_write(8'd9, 8'h41);
      table_write(8'd255, 8'hFF);
   endtask

   task automatic test_directed();
      logic [7:0] k [6];
      k = '{8'd4, 0, 0, 0, 0, 0};
      report(8'h00, k);
      report(8'h00, k);
      report(MOD_SHIFT, '{8'd4, 8'd5, 0, 0, 0, 0});
      report(8'h00, '{default: 8'h00});
      report(8'h01, '{8'd4, 0, 0, 0, 0, 0});
      report(8'h10, '{8'd4, 8'd127, 0, 0, 0, 0});
      report(8'hFF, '{default: 8'h00});
      report(8'h00, '{CAPS_KEY, 0, 0, 0, 0, 0});
      report(8'h00, '{CAPS_KEY, 8'd4, 0, 0, 0, 0});
      report(8'h02, '{default: 8'h00});
      report(8'h20, '{8'd4, 8'd255, 8'd128, 0, 0, 0});
      report(8'h44, '{8'd7, 8'd7, 8'd9, 8'd10, 8'd11, 8'd12});
      report(8'h00, '{8'd13, 8'd14, 8'd15, 8'd16, 8'd17, CAPS_KEY});
      tick(clock_us + 48'd2000000);
      tick(clock_us + 48'd4000000);
      tick(48'hFFFF_FFFF_FFFF);
      tick(48'd0);
      report(8'h00, '{default: 8'h00});
      tick(48'hFFFF_FFFF_FFFF);
      // unknown command, no result
      send_item(2'd3, 8'hAA, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
                48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF);
      wait_idle();
   endtask

   // wrapping deadlines
   task automatic test_wrap();
      csr_write(REG_DELAY, 24'hFFFFFF);
      csr_write(REG_PERIOD, 24'hFFFFFF);
      clock_us = 48'hFFFF_FFFF_0000;
      report(8'h00, '{8'd20, 8'd21, 0, 0, 0, 0});
      tick(48'hFFFF_FFFF_FFFF);
      tick(48'h0000_0010_0000);
      report(8'h00, '{default: 8'h00});
      wait_idle();
      clock_us = 48'd5000;
   endtask

   // random held-key sessions with ticks
   task automatic test_random(input int items);
      logic [7:0] k [6];
      int held;
      for (int n = 0; n < items; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               foreach (k[i]) k[i] = (i < held) ? prev_keys[i] : rand_key();
               held = $urandom_range(0, 6);
               report(8'($urandom), k);
            end
            4, 5, 6, 7: begin
               clock_us += $urandom_range(0, 60000);
               tick(clock_us);
            end
            8: report(8'($urandom), '{default: 8'h00});
            default: begin
               foreach (k[i]) k[i] = 8'($urandom);
               report(8'($urandom), k);
            end
         endcase
      end
      wait_idle();
   endtask

   // receiver stall pattern and result check
   logic [15:0] stall_lfsr = 16'hACE1;
   always @(posedge clock) begin
      key_out_t got, want;
      cycle_count <= cycle_count + 1;
      stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12]
                     ^ stall_lfsr[10]};
      rsp_ch.ready <= reset ? 1'b0 : (cycle_count[10] ? 1'b1 : stall_lfsr[1:0] != 2'b00);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.kind, rsp_ch.character, rsp_ch.caps_led, rsp_ch.last};
         if (expected_chars.size() == 0) begin
            $error("unexpected transfer kind=%0d character=%h", got.kind, got.character);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind expected %0d actual %0d", want.kind, got.kind);
               errors++;
            end
            if (got.character !== want.character) begin
               $error("character expected %h actual %h", want.character, got.character);
               errors++;
            end
            if (got.caps_led !== want.caps_led) begin
               $error("caps_led expected %0d actual %0d", want.caps_led, got.caps_led);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, got.last);
               errors++;
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_TICK;
      req_ch.modifier = '0;
      {req_ch.key0, req_ch.key1, req_ch.key2, req_ch.key3, req_ch.key4, req_ch.key5} = '0;
      req_ch.now_us = '0;
      req_ch.table_index = '0;
      req_ch.table_value = '0;
      rsp_ch.ready = 1'b0;
      delay_us = 24'd500000;
      period_us = 24'd50000;
      prev_keys = '{default: 8'h00};
      slot_key = '{default: 8'h00};
      slot_char = '{default: 8'h00};
      slot_deadline = '{default: 48'h0};
      caps_on = 1'b0;
      caps_was_down = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(REG_DELAY, 24'd30000);
      csr_write(REG_PERIOD, 24'd8000);
      test_keymap_load();
      test_directed();
      test_random(40);
      csr_write(REG_DELAY, 24'd0);
      csr_write(REG_PERIOD, 24'd0);
      test_random(40);
      test_wrap();
      csr_write(REG_DELAY, 24'd15000);
      csr_write(REG_PERIOD, 24'd3000);
      test_random(30);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
